@@ rtl/sadd_pkg.sv @@
package sadd_pkg;

  localparam int ANGLE_MAX    = 180;
  localparam int US_PER_S     = 1000000;
  localparam int NUM_REGS     = 4;
  localparam int LIMITS_W     = 32;
  localparam int PULSE_W      = 12;
  localparam int BAND_W       = 8;
  localparam int ANGLE_W      = 8;
  localparam int DUTY_W       = 14;
  localparam int CHAN_W       = 2;
  localparam int DIV_W        = 15;
  localparam int REG_IDX_W    = $clog2(NUM_REGS);

  localparam logic [LIMITS_W-1:0] LIMITS_RESET = 32'd10240500;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               broadcast;
    logic [CHAN_W-1:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [DUTY_W-1:0] duty;
    logic              updated;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_ADIV_GO,
    ST_ADIV_WAIT,
    ST_PULSE,
    ST_DMUL,
    ST_DDIV_GO,
    ST_DDIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_span;
    logic div_start;
    logic div_duty;
    logic pulse_step;
    logic mul_duty;
    logic out_load;
    logic next_chan;
  } cmd_t;

  typedef struct packed {
    logic present;
    logic div_done;
    logic last;
  } sts_t;

endpackage

@@ rtl/sadd_div.sv @@
module sadd_div
  import sadd_pkg::*;
#(
  parameter int NUMW = 26,
  parameter int QW   = 14,
  parameter int DVSR = 20000
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            sel_duty,
  input  logic [NUMW-1:0] numer,
  output logic            done,
  output logic [QW-1:0]   quot
);

  // floor(x / d) equals (x * ceil(2^s / d)) >> s for every x below 2^NUMW
  // when s = NUMW + clog2(d)
  localparam int RCW  = NUMW + 1;
  localparam int SH_A = NUMW + $clog2(ANGLE_MAX);
  localparam int SH_D = NUMW + $clog2(DVSR);
  localparam int PW   = ((SH_A > SH_D) ? SH_A : SH_D) + QW;

  localparam logic [RCW-1:0] REC_A =
    RCW'(((64'd1 << SH_A) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX));
  localparam logic [RCW-1:0] REC_D =
    RCW'(((64'd1 << SH_D) + 64'(DVSR) - 64'd1) / 64'(DVSR));

  logic [PW-1:0]  mul_r;
  logic           sel_r;
  logic           done_r;
  logic [RCW-1:0] rec;

  assign rec = sel_duty ? REC_D : REC_A;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_r <= PW'(numer) * PW'(rec);
      sel_r <= sel_duty;
    end
  end

  assign done = done_r;
  assign quot = sel_r ? mul_r[SH_D +: QW] : mul_r[SH_A +: QW];

endmodule

@@ rtl/sadd_ctrl.sv @@
module sadd_ctrl
  import sadd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // drop a request for a channel that is not built
          if (sts.present) begin
            state_nxt = ST_SPAN;
          end
        end
      end
      ST_SPAN: begin
        cmd.mul_span = 1'b1;
        state_nxt    = ST_ADIV_GO;
      end
      ST_ADIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_ADIV_WAIT;
      end
      ST_ADIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_PULSE;
        end
      end
      ST_PULSE: begin
        cmd.pulse_step = 1'b1;
        state_nxt      = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.mul_duty = 1'b1;
        state_nxt    = ST_DDIV_GO;
      end
      ST_DDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_duty  = 1'b1;
        state_nxt     = ST_DDIV_WAIT;
      end
      ST_DDIV_WAIT: begin
        if (sts.div_done) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_chan = 1'b1;
            state_nxt     = ST_SPAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sadd_dp.sv @@
module sadd_dp
  import sadd_pkg::*;
#(
  parameter int CHANNELS  = 4,
  parameter int DUTY_BITS = 14,
  parameter int PULSE_HZ  = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMITS_W-1:0]  cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output out_item_t            out_data
);

  localparam int QW        = (DUTY_BITS > PULSE_W) ? DUTY_BITS : PULSE_W;
  localparam int NUMW      = PULSE_W + DUTY_BITS;
  localparam int FRAME_US  = US_PER_S / PULSE_HZ;

  localparam logic [DUTY_BITS-1:0] DUTY_TOP = '1;
  localparam logic [CHAN_W-1:0]    CH_LAST  = CHAN_W'(CHANNELS - 1);

  logic [LIMITS_W-1:0] limits_r [NUM_REGS];
  logic [PULSE_W-1:0]  stored_r [NUM_REGS];

  logic [ANGLE_W-1:0]  angle_r;
  logic                bcast_r;
  logic [CHAN_W-1:0]   ch_r;
  logic [NUMW-1:0]     prod_r;
  logic [PULSE_W-1:0]  src_r;
  logic                upd_r;
  logic                sat_r;
  out_item_t           out_r;

  logic [ANGLE_W-1:0]  angle_c;
  logic [LIMITS_W-1:0] lim;
  logic [PULSE_W-1:0]  lo;
  logic [PULSE_W-1:0]  hi;
  logic [BAND_W-1:0]   band;
  logic [PULSE_W-1:0]  span;
  logic [PULSE_W-1:0]  pulse;
  logic [PULSE_W-1:0]  prev;
  logic [PULSE_W-1:0]  diff;
  logic                skip;
  logic                div_done;
  logic [QW-1:0]       quot;
  logic [DUTY_BITS-1:0]        duty_full;
  logic [DUTY_BITS+DUTY_W-1:0] duty_ext;

  always_comb begin
    if (in_data.angle[15]) begin
      angle_c = '0;
    end else if (in_data.angle[14:0] > 15'(ANGLE_MAX)) begin
      angle_c = ANGLE_W'(ANGLE_MAX);
    end else begin
      angle_c = in_data.angle[ANGLE_W-1:0];
    end
  end

  assign lim   = limits_r[ch_r];
  assign lo    = lim[PULSE_W-1:0];
  assign hi    = lim[2*PULSE_W-1:PULSE_W];
  assign band  = lim[LIMITS_W-1:2*PULSE_W];
  assign span  = (hi >= lo) ? (hi - lo) : '0;
  assign pulse = lo + quot[PULSE_W-1:0];
  assign prev  = stored_r[ch_r];
  assign diff  = (pulse >= prev) ? (pulse - prev) : (prev - pulse);
  // zero in the store means the channel was never set
  assign skip  = (prev != '0) && (diff < PULSE_W'(band));

  sadd_div #(
    .NUMW (NUMW),
    .QW   (QW),
    .DVSR (FRAME_US)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .sel_duty (cmd.div_duty),
    .numer    (prod_r),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        limits_r[i] <= LIMITS_RESET;
        stored_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        limits_r[cfg_index] <= cfg_data;
      end
      if (cmd.pulse_step && !skip) begin
        stored_r[ch_r] <= pulse;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      angle_r <= angle_c;
      bcast_r <= in_data.broadcast;
      ch_r    <= in_data.broadcast ? '0 : in_data.channel;
    end else if (cmd.next_chan) begin
      ch_r <= ch_r + 1'b1;
    end
    if (cmd.mul_span) begin
      prod_r <= NUMW'(span) * NUMW'(angle_r);
    end else if (cmd.mul_duty) begin
      prod_r <= NUMW'(src_r) * NUMW'(DUTY_TOP);
      // a pulse at or past the period saturates the duty
      sat_r  <= DIV_W'(src_r) >= DIV_W'(FRAME_US);
    end
    if (cmd.pulse_step) begin
      src_r <= skip ? prev : pulse;
      upd_r <= !skip;
    end
    if (cmd.out_load) begin
      out_r.out_channel <= ch_r;
      out_r.duty        <= duty_ext[DUTY_W-1:0];
      out_r.updated     <= upd_r;
      out_r.last        <= sts.last;
    end
  end

  assign duty_full = sat_r ? DUTY_TOP : quot[DUTY_BITS-1:0];
  assign duty_ext  = {{DUTY_W{1'b0}}, duty_full};

  assign sts.present  = in_data.broadcast ||
                        ({1'b0, in_data.channel} < (CHAN_W+1)'(CHANNELS));
  assign sts.div_done = div_done;
  assign sts.last     = !bcast_r || (ch_r == CH_LAST);

  assign out_data = out_r;

endmodule

@@ rtl/servo_angle_to_duty_deadband.sv @@
// Servo angle to PWM duty with a per-channel deadband.
// Input channel (in_valid/in_stall/in_data): one request carries an angle in
// degrees and either a single target channel or a broadcast flag. A request
// for a channel that is not built is taken and produces nothing.
// Result channel (out_valid/out_stall/out_data): one transfer per addressed
// channel, in channel order for a broadcast, with last set on the final one.
// Configuration (cfg_we/cfg_index/cfg_data): one 32-bit limits word per
// channel (min pulse, max pulse, deadband); write only while the block is idle.
// Each result is computed in steps: scale the span by the angle, divide by
// 180, apply the deadband, scale the pulse by the duty range, divide by the
// PWM period, present the result. Both divisions are by constants and use one
// registered reciprocal multiply.
// A new request is taken only after the last result of the previous one has
// been transferred; in_stall stays high while a request is in progress.
// When out_stall is high the result is held unchanged and no further work
// starts. Reset loads every limits word with 500/2500/0 us and clears the
// stored pulses, so every channel updates on its first request.
module servo_angle_to_duty_deadband
  import sadd_pkg::*;
#(
  parameter int CHANNELS  = 4,
  parameter int DUTY_BITS = 14,
  parameter int PULSE_HZ  = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMITS_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  sadd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sadd_dp #(
    .CHANNELS  (CHANNELS),
    .DUTY_BITS (DUTY_BITS),
    .PULSE_HZ  (PULSE_HZ)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // one request at a time: no input transfer while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> !out_valid)
    else $error("result produced after the last transfer of a request");

  a_bcast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.broadcast) |=> in_stall)
    else $error("broadcast request did not start work");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.out_channel} < (CHAN_W+1)'(CHANNELS)))
    else $error("result for a channel that is not built");

endmodule
